/* rtl/tter_pkg.sv */
// ============================================================================
// tter_pkg
// Shared types, constants and register codes of the terminal escape renderer.
// ============================================================================
package tter_pkg;

    // Font layout: glyphs per row of the font image.
    localparam int GLYPHS_PER_ROW = 32;

    // Glyph row of a code is code / GLYPHS_PER_ROW, formed as a multiply by a
    // rounded-up reciprocal. The shift is wide enough to be exact for 8-bit
    // codes and any glyph count up to 128.
    localparam int RECIP_SHIFT = 16;
    localparam int GLYPH_RECIP = ((1 << RECIP_SHIFT) + GLYPHS_PER_ROW - 1) / GLYPHS_PER_ROW;
    localparam int RECIP_W     = $clog2(GLYPH_RECIP + 1);

    // Depth of the command queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes (byte address / 4).
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_HALF_W = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FONT_TOP_Y   = 3'd6;

    // Register reset values.
    localparam logic [8:0] RST_ORIGIN_X     = 9'd0;
    localparam logic [9:0] RST_ORIGIN_Y     = 10'd0;
    localparam logic [9:0] RST_SCREEN_WIDTH = 10'd512;
    localparam logic [7:0] RST_COLUMN_COUNT = 8'd80;
    localparam logic [4:0] RST_GLYPH_HALF_W = 5'd3;
    localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd8;
    localparam logic [9:0] RST_FONT_TOP_Y   = 10'd212;

    // Blitter command kinds.
    localparam logic [1:0] CMD_FILL     = 2'd0;
    localparam logic [1:0] CMD_COPY_AND = 2'd1;
    localparam logic [1:0] CMD_COPY_XOR = 2'd2;

    // Fill color used by erase to end of line.
    localparam logic [7:0] ERASE_FILL = 8'h11;

    // Character codes.
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COLOR_MAX = 8'd47;
    localparam logic [7:0] CH_UP_K    = 8'h4B;
    localparam logic [7:0] CH_UP_H    = 8'h48;
    localparam logic [7:0] CH_UP_Y    = 8'h59;
    localparam logic [7:0] CH_LO_M    = 8'h6D;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_LO_Y    = 8'h79;

    typedef struct packed {
        logic [8:0] origin_x;
        logic [9:0] origin_y;
        logic [9:0] screen_width;
        logic [7:0] column_count;
        logic [4:0] glyph_half_width;
        logic [5:0] glyph_height;
        logic [9:0] font_top_y;
    } cfg_t;

    // One drawing job handed from the front to the back part.
    typedef struct packed {
        logic       erase;      // erase to end of line, else printable cell
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] code;
        logic [7:0] glyph_row;  // code / GLYPHS_PER_ROW
        logic [3:0] fg;
        logic       inv;
    } desc_t;

endpackage

/* rtl/tter_front.sv */
// ============================================================================
// tter_front
// Accepts character items, runs the escape parser and cursor state, and
// queues a drawing job for printable codes and erase to end of line.
// ============================================================================
module tter_front
    import tter_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       q_full,
    output logic       q_push,
    output desc_t      q_data
);

    typedef enum logic [3:0] {
        SUB_NONE  = 4'b0001,
        SUB_COLOR = 4'b0010,
        SUB_ROW   = 4'b0100,
        SUB_COL   = 4'b1000
    } sub_t;

    logic       in_esc_reg, in_esc_next;
    sub_t       sub_reg, sub_next;
    logic [7:0] prow_reg, prow_next;
    logic [3:0] fg_reg, fg_next;
    logic       inv_reg, inv_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;

    logic                        accept;
    logic                        emit;
    logic                        emit_erase;
    logic [7:0]                  c;
    logic [8+RECIP_W-1:0]        recip_prod;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_char_code;

    // Glyph row by reciprocal multiply.
    assign recip_prod = (8+RECIP_W)'(c) * (8+RECIP_W)'(GLYPH_RECIP);

    always_comb begin
        in_esc_next = in_esc_reg;
        sub_next    = sub_reg;
        prow_next   = prow_reg;
        fg_next     = fg_reg;
        inv_next    = inv_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        emit        = 1'b0;
        emit_erase  = 1'b0;
        if (in_esc_reg) begin
            priority if (c == CH_UP_K) begin
                emit        = 1'b1;
                emit_erase  = 1'b1;
                in_esc_next = 1'b0;
                col_next    = cfg.column_count;
            end else if (c == CH_LO_X) begin
                in_esc_next = 1'b1;
            end else if (c == CH_LO_M) begin
                sub_next = SUB_COLOR;
            end else if (sub_reg == SUB_COLOR) begin
                if (c <= CH_COLOR_MAX) begin
                    fg_next = c[3:0];
                end else begin
                    inv_next = !inv_reg;
                end
                sub_next    = SUB_NONE;
                in_esc_next = 1'b0;
            end else if (c == CH_LO_Y) begin
                in_esc_next = 1'b1;
            end else if (c == CH_UP_H) begin
                col_next    = 8'd0;
                row_next    = 8'd0;
                in_esc_next = 1'b0;
            end else if (c == CH_UP_Y) begin
                sub_next = SUB_ROW;
            end else if (sub_reg == SUB_ROW) begin
                prow_next = c;
                sub_next  = SUB_COL;
            end else if (sub_reg == SUB_COL) begin
                col_next    = c - CH_SPACE;
                row_next    = prow_reg - CH_SPACE;
                sub_next    = SUB_NONE;
                in_esc_next = 1'b0;
                prow_next   = 8'd0;
            end else begin
                in_esc_next = 1'b0;
            end
        end else begin
            priority if (c >= CH_SPACE) begin
                emit     = 1'b1;
                col_next = col_reg + 8'd1;
            end else if (c == CH_NL) begin
                row_next = row_reg + 8'd1;
            end else if (c == CH_CR) begin
                col_next = 8'd0;
            end else if (c == CH_ESC) begin
                in_esc_next = 1'b1;
            end else begin
                in_esc_next = 1'b0;
            end
        end
    end

    assign q_push          = accept && emit;
    assign q_data.erase     = emit_erase;
    assign q_data.col       = col_reg;
    assign q_data.row       = row_reg;
    assign q_data.code      = c;
    assign q_data.glyph_row = recip_prod[RECIP_SHIFT +: 8];
    assign q_data.fg        = fg_reg;
    assign q_data.inv       = inv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_esc_reg <= 1'b0;
            sub_reg    <= SUB_NONE;
            prow_reg   <= 8'd0;
            fg_reg     <= 4'd0;
            inv_reg    <= 1'b0;
            col_reg    <= 8'd0;
            row_reg    <= 8'd0;
        end else if (accept) begin
            in_esc_reg <= in_esc_next;
            sub_reg    <= sub_next;
            prow_reg   <= prow_next;
            fg_reg     <= fg_next;
            inv_reg    <= inv_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

/* rtl/tter_queue.sv */
// ============================================================================
// tter_queue
// Short first-in first-out queue of drawing jobs between front and back.
// ============================================================================
module tter_queue
    import tter_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output desc_t pop_data
);

    desc_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = mem_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/tter_back.sv */
// ============================================================================
// tter_back
// Takes drawing jobs from the queue, forms cell geometry and emits blitter
// commands through an output register.
// ============================================================================
module tter_back
    import tter_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  desc_t      q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_cmd_kind,
    output logic [9:0] m_src_x,
    output logic [9:0] m_src_y,
    output logic [9:0] m_dst_x,
    output logic [9:0] m_dst_y,
    output logic [9:0] m_rect_width,
    output logic [5:0] m_rect_height,
    output logic [7:0] m_fill_byte,
    output logic       m_last
);

    // Job stage: products are registered here.
    logic        job_valid_reg, job_valid_next;
    logic        job_phase_reg, job_phase_next;
    logic        job_erase_reg;
    logic [3:0]  job_fg_reg;
    logic        job_inv_reg;
    logic [13:0] job_xoff_reg;
    logic [9:0]  job_rowprod_reg;
    logic [7:0]  job_n_reg;
    logic [9:0]  job_mprod_reg;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_cmd_kind_reg;
    logic [9:0]  m_src_x_reg;
    logic [9:0]  m_src_y_reg;
    logic [9:0]  m_dst_x_reg;
    logic [9:0]  m_dst_y_reg;
    logic [9:0]  m_rect_width_reg;
    logic [5:0]  m_rect_height_reg;
    logic [7:0]  m_fill_byte_reg;
    logic        m_last_reg;

    logic        out_load, job_done, job_load;
    logic [5:0]  gw;
    logic [13:0] xoff_new, rowprod_new, mprod_new;
    logic [15:0] mg_new;
    logic [7:0]  n_new;
    logic [13:0] sx_prod;
    logic [9:0]  dx, dy, sx, sy, erase_w;
    logic [1:0]  kind_next;
    logic [9:0]  src_x_next, src_y_next, width_next;
    logic [7:0]  fill_next;
    logic        last_next;

    assign gw       = {cfg.glyph_half_width, 1'b0};
    assign out_load = job_valid_reg && (!m_valid_reg || m_ready);
    assign job_done = out_load && (job_erase_reg || job_phase_reg);
    assign job_load = q_valid && (!job_valid_reg || job_done);
    assign q_pop    = job_load;

    // Job stage arithmetic, one multiply per path.
    assign xoff_new    = 14'(q_data.col) * 14'(gw);
    assign rowprod_new = 14'(q_data.row) * 14'(cfg.glyph_height);
    assign mprod_new   = 14'(q_data.glyph_row) * 14'(cfg.glyph_height);
    assign mg_new      = 16'(q_data.glyph_row) * 16'(GLYPHS_PER_ROW);
    assign n_new       = q_data.code - mg_new[7:0];

    // Output stage arithmetic.
    assign sx_prod = 14'(job_n_reg) * 14'(gw);
    assign dx      = 10'(cfg.origin_x) + job_xoff_reg[9:0];
    assign dy      = cfg.origin_y + job_rowprod_reg;
    assign sx      = sx_prod[9:0];
    assign sy      = cfg.font_top_y + job_mprod_reg;
    assign erase_w = (14'(cfg.screen_width) > job_xoff_reg)
                   ? (cfg.screen_width - job_xoff_reg[9:0]) : 10'd0;

    always_comb begin
        if (job_erase_reg) begin
            kind_next  = CMD_FILL;
            src_x_next = 10'd0;
            src_y_next = 10'd0;
            width_next = erase_w;
            fill_next  = ERASE_FILL;
            last_next  = 1'b1;
        end else if (!job_phase_reg) begin
            kind_next  = CMD_FILL;
            src_x_next = 10'd0;
            src_y_next = 10'd0;
            width_next = 10'(gw);
            fill_next  = {job_fg_reg, job_fg_reg};
            last_next  = 1'b0;
        end else begin
            kind_next  = job_inv_reg ? CMD_COPY_XOR : CMD_COPY_AND;
            src_x_next = sx;
            src_y_next = sy;
            width_next = 10'(gw);
            fill_next  = 8'd0;
            last_next  = 1'b1;
        end
    end

    always_comb begin
        job_valid_next = job_valid_reg;
        job_phase_next = job_phase_reg;
        if (job_load) begin
            job_valid_next = 1'b1;
            job_phase_next = 1'b0;
        end else if (job_done) begin
            job_valid_next = 1'b0;
        end else if (out_load) begin
            job_phase_next = 1'b1;
        end
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            job_phase_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            job_phase_reg <= job_phase_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_erase_reg   <= q_data.erase;
            job_fg_reg      <= q_data.fg;
            job_inv_reg     <= q_data.inv;
            job_xoff_reg    <= xoff_new;
            job_rowprod_reg <= rowprod_new[9:0];
            job_n_reg       <= n_new;
            job_mprod_reg   <= mprod_new[9:0];
        end
        if (out_load) begin
            m_cmd_kind_reg    <= kind_next;
            m_src_x_reg       <= src_x_next;
            m_src_y_reg       <= src_y_next;
            m_dst_x_reg       <= dx;
            m_dst_y_reg       <= dy;
            m_rect_width_reg  <= width_next;
            m_rect_height_reg <= cfg.glyph_height;
            m_fill_byte_reg   <= fill_next;
            m_last_reg        <= last_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cmd_kind    = m_cmd_kind_reg;
    assign m_src_x       = m_src_x_reg;
    assign m_src_y       = m_src_y_reg;
    assign m_dst_x       = m_dst_x_reg;
    assign m_dst_y       = m_dst_y_reg;
    assign m_rect_width  = m_rect_width_reg;
    assign m_rect_height = m_rect_height_reg;
    assign m_fill_byte   = m_fill_byte_reg;
    assign m_last        = m_last_reg;

endmodule

/* rtl/text_terminal_escape_renderer.sv */
// ============================================================================
// text_terminal_escape_renderer
// Character terminal with an escape sequence parser that drives a blitter.
// ============================================================================
// Usage:
// The input channel (s_valid, s_ready, s_char_code) takes one character code
// per item. The result channel (m_valid, m_ready, m_*) gives blitter
// commands: a printable code yields a background fill followed by a glyph
// copy, erase to end of line yields one fill, all other codes only change
// cursor, color or parser state. m_last marks the final command of an item.
// A printable item passes the job queue, the job register of the back part
// and the output register before its first command shows; its glyph copy
// follows once the cell fill is taken. Commands leave at one per cycle while
// m_ready is high; items that make no command are taken once per cycle while the
// two-entry job queue has room.
// When the receiver stalls, commands wait in the output register, the back
// part holds one job and the queue fills; s_ready falls only when the queue
// is full. Synchronous reset (aresetn low) clears the cursor, the color, the
// inversion flag, the parser, the job queue and the back part, and sets the configuration
// registers to their defaults. Registers are written over the APB port at
// byte address 4*index and should only change while the block is idle.
// ============================================================================
module text_terminal_escape_renderer
    import tter_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_cmd_kind,
    output logic [9:0]  m_src_x,
    output logic [9:0]  m_src_y,
    output logic [9:0]  m_dst_x,
    output logic [9:0]  m_dst_y,
    output logic [9:0]  m_rect_width,
    output logic [5:0]  m_rect_height,
    output logic [7:0]  m_fill_byte,
    output logic        m_last
);

    // Configuration registers. They are read live by both parts; the rule
    // that they only change while idle keeps every command consistent.
    cfg_t                 cfg_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x         <= RST_ORIGIN_X;
            cfg_reg.origin_y         <= RST_ORIGIN_Y;
            cfg_reg.screen_width     <= RST_SCREEN_WIDTH;
            cfg_reg.column_count     <= RST_COLUMN_COUNT;
            cfg_reg.glyph_half_width <= RST_GLYPH_HALF_W;
            cfg_reg.glyph_height     <= RST_GLYPH_HEIGHT;
            cfg_reg.font_top_y       <= RST_FONT_TOP_Y;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ORIGIN_X:     cfg_reg.origin_x         <= pwdata[8:0];
                REG_ORIGIN_Y:     cfg_reg.origin_y         <= pwdata[9:0];
                REG_SCREEN_WIDTH: cfg_reg.screen_width     <= pwdata[9:0];
                REG_COLUMN_COUNT: cfg_reg.column_count     <= pwdata[7:0];
                REG_GLYPH_HALF_W: cfg_reg.glyph_half_width <= pwdata[4:0];
                REG_GLYPH_HEIGHT: cfg_reg.glyph_height     <= pwdata[5:0];
                REG_FONT_TOP_Y:   cfg_reg.font_top_y       <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X:     prdata = 32'(cfg_reg.origin_x);
            REG_ORIGIN_Y:     prdata = 32'(cfg_reg.origin_y);
            REG_SCREEN_WIDTH: prdata = 32'(cfg_reg.screen_width);
            REG_COLUMN_COUNT: prdata = 32'(cfg_reg.column_count);
            REG_GLYPH_HALF_W: prdata = 32'(cfg_reg.glyph_half_width);
            REG_GLYPH_HEIGHT: prdata = 32'(cfg_reg.glyph_height);
            REG_FONT_TOP_Y:   prdata = 32'(cfg_reg.font_top_y);
            default:          prdata = 32'd0;
        endcase
    end

    // Front part: parser and cursor; it pushes a job for every item that
    // draws something.
    logic  q_full, q_push, q_pop, q_valid;
    desc_t q_in, q_out;

    tter_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    tter_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    // Back part: geometry and command output.
    tter_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cmd_kind    (m_cmd_kind),
        .m_src_x       (m_src_x),
        .m_src_y       (m_src_y),
        .m_dst_x       (m_dst_x),
        .m_dst_y       (m_dst_y),
        .m_rect_width  (m_rect_width),
        .m_rect_height (m_rect_height),
        .m_fill_byte   (m_fill_byte),
        .m_last        (m_last)
    );

`ifndef SYNTHESIS
    // The first command of a two-command item is always the cell fill.
    a_first_is_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_cmd_kind == CMD_FILL))
        else $error("non-final command is not a fill");

    // Once the cell fill is taken, the glyph copy follows in the next cycle.
    a_copy_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
        (m_valid && m_last && m_cmd_kind != CMD_FILL))
        else $error("glyph copy did not follow the cell fill");

    // Copies carry no fill color and always end their item.
    a_copy_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_cmd_kind != CMD_FILL) |-> (m_fill_byte == 8'd0 && m_last))
        else $error("copy command with fill color or not last");
`endif

endmodule
